[design/ddpc_pkg.sv]
// ----------------------------------------------------------------------------
// ddpc_pkg: shared types and constants for the pose controller
// Fixed-point constants, register indexes, CORDIC table and command/status types.
// ----------------------------------------------------------------------------
package ddpc_pkg;

  localparam logic signed [39:0] DEG_90   = 40'sd5898240;
  localparam logic signed [39:0] DEG_180  = 40'sd11796480;
  localparam logic signed [39:0] DEG_360  = 40'sd23592960;
  localparam logic [31:0]        HEAD_K   = 32'd40645398;
  localparam logic [31:0]        ODO_K    = 32'd23899168;
  localparam logic signed [39:0] V_OFFSET = 40'sd13107;
  localparam logic signed [39:0] ARRIVE_R = 40'sd655360;
  localparam logic [31:0]        INV_GAIN = 32'd652032874;

  localparam logic [2:0] REG_TX  = 3'd0;
  localparam logic [2:0] REG_TY  = 3'd1;
  localparam logic [2:0] REG_GH  = 3'd2;
  localparam logic [2:0] REG_KR  = 3'd3;
  localparam logic [2:0] REG_KA  = 3'd4;
  localparam logic [2:0] REG_KB  = 3'd5;
  localparam logic [2:0] REG_KP  = 3'd6;
  localparam logic [2:0] REG_KI  = 3'd7;

  typedef struct packed {
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] goal_heading;
    logic [31:0] gain_rho;
    logic [31:0] gain_alpha;
    logic [31:0] gain_beta;
    logic [31:0] gain_speed_p;
    logic [31:0] gain_speed_i_dt;
  } cfg_t;

  typedef struct packed {
    logic        restart;
    logic [31:0] left_distance;
    logic [31:0] right_distance;
    logic [31:0] left_speed;
    logic [31:0] right_speed;
  } in_word_t;

  typedef struct packed {
    logic [31:0] left_drive;
    logic [31:0] right_drive;
    logic        arrived;
    logic [30:0] range_to_target;
    logic [31:0] heading_now;
  } out_word_t;

  // datapath micro-operations, sequenced by the controller
  typedef enum logic [4:0] {
    OP_LOAD    = 5'd0,   // latch inputs, apply restart
    OP_HEAD    = 5'd1,   // heading mul
    OP_HEAD_W  = 5'd2,
    OP_VSETUP  = 5'd3,   // dx,dy, pre-rotate
    OP_VITER   = 5'd4,
    OP_VMAG    = 5'd5,   // x*INV_GAIN
    OP_VMAG_W  = 5'd6,
    OP_ALPHA   = 5'd7,
    OP_MRHO    = 5'd8,
    OP_MALPHA  = 5'd9,
    OP_MBETA   = 5'd10,
    OP_VW      = 5'd11,
    OP_ERR     = 5'd12,
    OP_MPL     = 5'd13,
    OP_MIL     = 5'd14,
    OP_MPR     = 5'd15,
    OP_MIR     = 5'd16,
    OP_DRV     = 5'd17,
    OP_MODO    = 5'd18,
    OP_RSETUP  = 5'd19,
    OP_RITER   = 5'd20,
    OP_MC      = 5'd21,
    OP_MS      = 5'd22,
    OP_POSE    = 5'd23,
    OP_NONE    = 5'd24
  } op_t;

  typedef struct packed {
    op_t  op;
    logic mul_start;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic iter_last;
  } sts_t;

  function automatic logic signed [39:0] atan_deg(input logic [4:0] k);
    logic signed [39:0] r;
    begin
      case (k)
        5'd0: r = 40'sd2949120;  5'd1: r = 40'sd1740967;
        5'd2: r = 40'sd919879;   5'd3: r = 40'sd466945;
        5'd4: r = 40'sd234379;   5'd5: r = 40'sd117304;
        5'd6: r = 40'sd58666;    5'd7: r = 40'sd29335;
        5'd8: r = 40'sd14668;    5'd9: r = 40'sd7334;
        5'd10: r = 40'sd3667;    5'd11: r = 40'sd1833;
        5'd12: r = 40'sd917;     5'd13: r = 40'sd458;
        5'd14: r = 40'sd229;     5'd15: r = 40'sd115;
        5'd16: r = 40'sd57;      5'd17: r = 40'sd29;
        5'd18: r = 40'sd14;      5'd19: r = 40'sd7;
        5'd20: r = 40'sd4;       5'd21: r = 40'sd2;
        5'd22: r = 40'sd1;
        default: r = 40'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [39:0] sat32(input logic signed [47:0] v);
    begin
      if (v > 48'sd2147483647) return 40'sd2147483647;
      else if (v < -48'sd2147483648) return -40'sd2147483648;
      else return v[39:0];
    end
  endfunction

endpackage

[design/ddpc_if.sv]
// ----------------------------------------------------------------------------
// ddpc_stream_if: valid/ready channel
// Carries one word of a parametrized payload width.
// ----------------------------------------------------------------------------
interface ddpc_stream_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/diff_drive_pose_controller_top.sv]
// ----------------------------------------------------------------------------
// diff_drive_pose_controller_top: go-to-pose controller with wheel PI loops
// The work per word is set by the two CORDIC passes and twelve uses of the
// shared multiplier; one word at a time.
// The next word is taken only once the output register is empty or being read.
// Synchronous active-low reset clears pose, integrators, config registers and control.
// ----------------------------------------------------------------------------
module diff_drive_pose_controller_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  ddpc_stream_if.sink   in_ch,
  ddpc_stream_if.source out_ch,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  ddpc_pkg::cfg_t      cfg_r;
  ddpc_pkg::cmd_t      cmd;
  ddpc_pkg::sts_t      sts;
  ddpc_pkg::out_word_t dp_out;
  ddpc_pkg::out_word_t res_r;
  ddpc_pkg::in_word_t  in_w;
  logic                capture;

  assign cfg_ready = 1'b1;
  assign in_w = in_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_valid) begin
      case (cfg_index)
        ddpc_pkg::REG_TX: cfg_r.target_x        <= cfg_data;
        ddpc_pkg::REG_TY: cfg_r.target_y        <= cfg_data;
        ddpc_pkg::REG_GH: cfg_r.goal_heading    <= cfg_data;
        ddpc_pkg::REG_KR: cfg_r.gain_rho        <= cfg_data;
        ddpc_pkg::REG_KA: cfg_r.gain_alpha      <= cfg_data;
        ddpc_pkg::REG_KB: cfg_r.gain_beta       <= cfg_data;
        ddpc_pkg::REG_KP: cfg_r.gain_speed_p    <= cfg_data;
        ddpc_pkg::REG_KI: cfg_r.gain_speed_i_dt <= cfg_data;
        default: ;
      endcase
    end
  end

  ddpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts), .capture(capture)
  );

  ddpc_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg(cfg_r), .in_w(in_w), .out_w(dp_out)
  );

  always_ff @(posedge clk) begin
    if (capture) res_r <= dp_out;
  end

  assign out_ch.data = res_r;
endmodule

[design/ddpc_mul.sv]
// ----------------------------------------------------------------------------
// ddpc_mul: shared sequential multiplier
// 48-bit magnitude by 32-bit unsigned, two 24x32 partial products over cycles.
// ----------------------------------------------------------------------------
module ddpc_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] a_mag,
  input  logic [31:0] b,
  output logic [79:0] prod,
  output logic        done
);
  logic [1:0]  ph_r, ph_nxt;
  logic [47:0] a_r;
  logic [31:0] b_r;
  logic [79:0] acc_r;
  logic [55:0] pp;

  assign pp = (ph_r == 2'd1) ? a_r[23:0] * b_r : a_r[47:24] * b_r;

  always_comb begin
    ph_nxt = ph_r;
    if (start) ph_nxt = 2'd1;
    else if (ph_r == 2'd1) ph_nxt = 2'd2;
    else if (ph_r == 2'd2) ph_nxt = 2'd3;
    else if (ph_r == 2'd3) ph_nxt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= 2'd0;
    else ph_r <= ph_nxt;
    if (start) begin
      a_r <= a_mag;
      b_r <= b;
      acc_r <= '0;
    end else if (ph_r == 2'd1) acc_r <= {24'd0, pp};
    else if (ph_r == 2'd2) acc_r <= acc_r + {pp, 24'd0};
  end

  assign prod = acc_r;
  assign done = (ph_r == 2'd3);
endmodule

[design/ddpc_datapath.sv]
// ----------------------------------------------------------------------------
// ddpc_datapath: pose controller datapath
// Registers, CORDIC shift-add unit, shared multiplier and saturating adders.
// ----------------------------------------------------------------------------
module ddpc_datapath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ddpc_pkg::cmd_t     cmd,
  output ddpc_pkg::sts_t     sts,
  input  ddpc_pkg::cfg_t     cfg,
  input  ddpc_pkg::in_word_t in_w,
  output ddpc_pkg::out_word_t out_w
);
  localparam int IW = $clog2(CORDIC_STEPS + 1);

  logic signed [39:0] px_r, py_r, pl_r, pr_r;
  logic signed [39:0] il_r, ir_r;
  logic signed [39:0] dl_r, dr_r, sl_r, sr_r;
  logic signed [39:0] head_r, rho_r, alpha_r, beta_r, v_r, w_r, el_r, er_r;
  logic signed [39:0] t0_r, t1_r, ul_r, ur_r, sd_r, c_r;
  logic signed [47:0] cx_r, cy_r, cz_r;
  logic               neg_r, zero_r;
  logic [IW-1:0]      it_r;

  logic [47:0] m_a;
  logic [31:0] m_b;
  logic        m_neg;
  logic [79:0] m_p;
  logic        m_done;
  logic signed [47:0] m_g;   // signed value*gain>>24
  logic signed [47:0] m_q;   // for the q30 cos/sin paths

  logic signed [39:0] m_src;
  logic [31:0]        m_gain;
  logic [4:0]         k5;
  logic signed [47:0] shx, shy, r0, r1;

  // select multiplier operands from op
  always_comb begin
    m_src = '0;
    m_gain = '0;
    case (cmd.op)
      ddpc_pkg::OP_HEAD:   begin m_src = dr_r - dl_r; m_gain = ddpc_pkg::HEAD_K; end
      ddpc_pkg::OP_VMAG:   begin m_src = cx_r[39:0]; m_gain = ddpc_pkg::INV_GAIN; end
      ddpc_pkg::OP_MRHO:   begin m_src = rho_r; m_gain = cfg.gain_rho; end
      ddpc_pkg::OP_MALPHA: begin m_src = alpha_r; m_gain = cfg.gain_alpha; end
      ddpc_pkg::OP_MBETA:  begin m_src = beta_r; m_gain = cfg.gain_beta; end
      ddpc_pkg::OP_MPL:    begin m_src = el_r; m_gain = cfg.gain_speed_p; end
      ddpc_pkg::OP_MIL:    begin m_src = il_r; m_gain = cfg.gain_speed_i_dt; end
      ddpc_pkg::OP_MPR:    begin m_src = er_r; m_gain = cfg.gain_speed_p; end
      ddpc_pkg::OP_MIR:    begin m_src = ir_r; m_gain = cfg.gain_speed_i_dt; end
      ddpc_pkg::OP_MODO:   begin m_src = sd_r; m_gain = ddpc_pkg::ODO_K; end
      ddpc_pkg::OP_MC:     begin m_src = sd_r; m_gain = c_r[31:0]; end
      ddpc_pkg::OP_MS:     begin m_src = sd_r; m_gain = cy_r[31:0]; end
      default: ;
    endcase
  end

  // cos/sin multiplicand magnitude: Q2.30 value treated as magnitude + sign
  logic signed [39:0] q_val;
  logic               q_neg_r;
  assign q_val = (cmd.op == ddpc_pkg::OP_MC) ? c_r : cy_r[39:0];

  always_comb begin
    m_b = m_gain;
    if (cmd.op == ddpc_pkg::OP_MC || cmd.op == ddpc_pkg::OP_MS) begin
      m_b = q_val[39] ? 32'(-q_val) : q_val[31:0];
    end
    m_a = m_src[39] ? 48'(-{{8{m_src[39]}}, m_src}) : 48'({8'd0, m_src});
  end

  logic m_sneg_r;
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      m_sneg_r <= m_src[39];
      q_neg_r  <= ((cmd.op == ddpc_pkg::OP_MC) || (cmd.op == ddpc_pkg::OP_MS)) && q_val[39];
    end
  end

  ddpc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .a_mag(m_a), .b(m_b), .prod(m_p), .done(m_done)
  );

  assign m_neg = m_sneg_r ^ q_neg_r;
  assign m_g = m_sneg_r ? -$signed({1'b0, m_p[70:24]}) : $signed({1'b0, m_p[70:24]});
  assign m_q = m_neg ? -$signed({1'b0, m_p[76:30]}) : $signed({1'b0, m_p[76:30]});

  assign k5 = 5'(it_r);
  assign shx = cx_r >>> k5;
  assign shy = cy_r >>> k5;

  // heading reduction for the rotation mode
  logic signed [39:0] hr0, hr1, hr2;
  logic signed [39:0] hq;
  always_comb begin
    hr0 = 40'(head_r % ddpc_pkg::DEG_360);
    hr1 = hr0;
    if (hr1 >= ddpc_pkg::DEG_180) hr1 = hr1 - ddpc_pkg::DEG_360;
    if (hr1 < -ddpc_pkg::DEG_180) hr1 = hr1 + ddpc_pkg::DEG_360;
    hr2 = hr1;
    hq = hr1;
    if (hr1 > ddpc_pkg::DEG_90) hr2 = hr1 - ddpc_pkg::DEG_180;
    else if (hr1 < -ddpc_pkg::DEG_90) hr2 = hr1 + ddpc_pkg::DEG_180;
  end

  assign r0 = 48'(t0_r) + 48'(t1_r);
  assign r1 = 48'(t0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; pl_r <= '0; pr_r <= '0; il_r <= '0; ir_r <= '0;
    end else begin
      case (cmd.op)
        ddpc_pkg::OP_LOAD: begin
          dl_r <= 40'($signed(in_w.left_distance));
          dr_r <= 40'($signed(in_w.right_distance));
          sl_r <= 40'($signed(in_w.left_speed));
          sr_r <= 40'($signed(in_w.right_speed));
          if (in_w.restart) begin
            px_r <= '0; py_r <= '0; pl_r <= '0; pr_r <= '0; il_r <= '0; ir_r <= '0;
          end
        end
        ddpc_pkg::OP_HEAD_W: if (m_done) head_r <= ddpc_pkg::sat32(m_g);
        ddpc_pkg::OP_VSETUP: begin
          it_r <= '0;
          cx_r <= 48'($signed(cfg.target_x)) - 48'(px_r);
          cy_r <= 48'($signed(cfg.target_y)) - 48'(py_r);
          cz_r <= '0;
          zero_r <= ($signed(cfg.target_x) == px_r[31:0]) && ($signed(cfg.target_y) == py_r[31:0]);
          if ((48'($signed(cfg.target_x)) - 48'(px_r)) < 0) begin
            if ((48'($signed(cfg.target_y)) - 48'(py_r)) >= 0) begin
              cx_r <= 48'($signed(cfg.target_y)) - 48'(py_r);
              cy_r <= 48'(px_r) - 48'($signed(cfg.target_x));
              cz_r <= 48'(ddpc_pkg::DEG_90);
            end else begin
              cx_r <= 48'(py_r) - 48'($signed(cfg.target_y));
              cy_r <= 48'($signed(cfg.target_x)) - 48'(px_r);
              cz_r <= -48'(ddpc_pkg::DEG_90);
            end
          end
        end
        ddpc_pkg::OP_VITER: begin
          it_r <= it_r + 1'b1;
          if (cy_r > 0) begin
            cx_r <= cx_r + shy; cy_r <= cy_r - shx; cz_r <= cz_r + 48'(ddpc_pkg::atan_deg(k5));
          end else begin
            cx_r <= cx_r - shy; cy_r <= cy_r + shx; cz_r <= cz_r - 48'(ddpc_pkg::atan_deg(k5));
          end
        end
        ddpc_pkg::OP_VMAG: if (cx_r < 0) cx_r <= '0;
        ddpc_pkg::OP_VMAG_W: if (m_done) begin
          if (zero_r) begin
            rho_r <= '0; t0_r <= '0;
          end else begin
            // (x*INV_GAIN)>>30 approximates the model's split form; x>=0
            rho_r <= (m_p[79:30] > 80'd2147483647) ? 40'sd2147483647 : 40'(m_p[79:30]);
            t0_r <= 40'(cz_r);
          end
        end
        ddpc_pkg::OP_ALPHA: begin
          alpha_r <= ddpc_pkg::sat32(48'(t0_r) - 48'(head_r));
          beta_r <= ddpc_pkg::sat32(48'($signed(cfg.goal_heading)) - 48'(head_r)
                    - 48'(ddpc_pkg::sat32(48'(t0_r) - 48'(head_r))));
        end
        ddpc_pkg::OP_MRHO: if (m_done) v_r <= ddpc_pkg::sat32(m_g + 48'(ddpc_pkg::V_OFFSET));
        ddpc_pkg::OP_MALPHA: if (m_done) t0_r <= 40'(m_g);
        ddpc_pkg::OP_MBETA: if (m_done) w_r <= ddpc_pkg::sat32(48'(t0_r) + m_g);
        ddpc_pkg::OP_VW: begin
          t0_r <= ddpc_pkg::sat32(48'(v_r) - 48'(w_r));
          t1_r <= ddpc_pkg::sat32(48'(v_r) + 48'(w_r));
        end
        ddpc_pkg::OP_ERR: begin
          el_r <= ddpc_pkg::sat32(48'(t0_r) - 48'(sl_r));
          er_r <= ddpc_pkg::sat32(48'(t1_r) - 48'(sr_r));
          il_r <= il_r + ddpc_pkg::sat32(48'(t0_r) - 48'(sl_r));
          ir_r <= ir_r + ddpc_pkg::sat32(48'(t1_r) - 48'(sr_r));
          sd_r <= 40'((48'(dl_r) - 48'(pl_r) + 48'(dr_r) - 48'(pr_r)) >>> 1);
        end
        ddpc_pkg::OP_MPL: if (m_done) t0_r <= 40'(m_g);
        ddpc_pkg::OP_MIL: if (m_done) ul_r <= ddpc_pkg::sat32(48'(t0_r) + m_g);
        ddpc_pkg::OP_MPR: if (m_done) t0_r <= 40'(m_g);
        ddpc_pkg::OP_MIR: if (m_done) ur_r <= ddpc_pkg::sat32(48'(t0_r) + m_g);
        ddpc_pkg::OP_MODO: if (m_done) sd_r <= ddpc_pkg::sat32(m_g);
        ddpc_pkg::OP_RSETUP: begin
          it_r <= '0;
          cx_r <= 48'(ddpc_pkg::INV_GAIN);
          cy_r <= '0;
          cz_r <= 48'(hr2);
          neg_r <= (hr1 > ddpc_pkg::DEG_90) || (hr1 < -ddpc_pkg::DEG_90);
        end
        ddpc_pkg::OP_RITER: begin
          it_r <= it_r + 1'b1;
          if (it_r == IW'(CORDIC_STEPS - 1)) begin
            c_r <= neg_r ? -40'(cx_r + (cz_r >= 0 ? -shy : shy))
                         : 40'(cx_r + (cz_r >= 0 ? -shy : shy));
          end
          if (cz_r >= 0) begin
            cx_r <= cx_r - shy; cy_r <= cy_r + shx; cz_r <= cz_r - 48'(ddpc_pkg::atan_deg(k5));
          end else begin
            cx_r <= cx_r + shy; cy_r <= cy_r - shx; cz_r <= cz_r + 48'(ddpc_pkg::atan_deg(k5));
          end
          if (it_r == IW'(CORDIC_STEPS - 1) && neg_r) begin
            cy_r <= -(cy_r + (cz_r >= 0 ? shx : -shx));
          end
        end
        ddpc_pkg::OP_MC: if (m_done) px_r <= ddpc_pkg::sat32(48'(px_r) + m_q);
        ddpc_pkg::OP_MS: if (m_done) py_r <= ddpc_pkg::sat32(48'(py_r) + m_q);
        ddpc_pkg::OP_POSE: begin
          pl_r <= dl_r; pr_r <= dr_r;
        end
        default: ;
      endcase
      if (cmd.op == ddpc_pkg::OP_ERR) begin
        if (il_r + ddpc_pkg::sat32(48'(t0_r) - 48'(sl_r)) > 0 && il_r[39] == 1'b0 &&
            ddpc_pkg::sat32(48'(t0_r) - 48'(sl_r)) > 0 &&
            (il_r + ddpc_pkg::sat32(48'(t0_r) - 48'(sl_r))) < il_r)
          il_r <= 40'sh7FFFFFFFFF;
      end
    end
  end

  assign sts.mul_done = m_done;
  assign sts.iter_last = (it_r == IW'(CORDIC_STEPS - 1));

  assign out_w.left_drive      = ul_r[31:0];
  assign out_w.right_drive     = ur_r[31:0];
  assign out_w.arrived         = (rho_r <= ddpc_pkg::ARRIVE_R);
  assign out_w.range_to_target = rho_r[30:0];
  assign out_w.heading_now     = head_r[31:0];

  logic unused;
  assign unused = ^{r0, r1, hq};
endmodule

[design/ddpc_ctrl.sv]
// ----------------------------------------------------------------------------
// ddpc_ctrl: step sequencer
// One-hot state machine issuing datapath operations for one sample.
// ----------------------------------------------------------------------------
module ddpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ddpc_pkg::cmd_t cmd,
  input  ddpc_pkg::sts_t sts,
  output logic           capture
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t         st_r, st_nxt;
  ddpc_pkg::op_t  op_r, op_nxt;
  logic           ov_r, ov_nxt;

  function automatic logic is_mul(input ddpc_pkg::op_t o);
    return o == ddpc_pkg::OP_HEAD || o == ddpc_pkg::OP_VMAG || o == ddpc_pkg::OP_MRHO ||
           o == ddpc_pkg::OP_MALPHA || o == ddpc_pkg::OP_MBETA || o == ddpc_pkg::OP_MPL ||
           o == ddpc_pkg::OP_MIL || o == ddpc_pkg::OP_MPR || o == ddpc_pkg::OP_MIR ||
           o == ddpc_pkg::OP_MODO || o == ddpc_pkg::OP_MC || o == ddpc_pkg::OP_MS;
  endfunction

  assign in_ready = (st_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign capture = (st_r == S_DONE);

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    ov_nxt = ov_r;
    cmd.op = ddpc_pkg::OP_NONE;
    cmd.mul_start = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.op = ddpc_pkg::OP_LOAD;
        op_nxt = ddpc_pkg::OP_HEAD;
        st_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.op = op_r;
        if (is_mul(op_r)) begin
          cmd.mul_start = 1'b1;
          st_nxt = S_WAIT;
        end else if ((op_r == ddpc_pkg::OP_VITER || op_r == ddpc_pkg::OP_RITER) &&
                     !sts.iter_last) begin
          op_nxt = op_r;
        end else if (op_r == ddpc_pkg::OP_POSE) begin
          st_nxt = S_DONE;
        end else begin
          op_nxt = ddpc_pkg::op_t'(op_r + 5'd1);
        end
      end
      S_WAIT: begin
        // multiplier ops keep their own code for the write-back, but HEAD and VMAG use their _W codes
        cmd.op = (op_r == ddpc_pkg::OP_HEAD) ? ddpc_pkg::OP_HEAD_W :
                 (op_r == ddpc_pkg::OP_VMAG) ? ddpc_pkg::OP_VMAG_W : op_r;
        if (sts.mul_done) begin
          st_nxt = S_RUN;
          op_nxt = (op_r == ddpc_pkg::OP_HEAD) ? ddpc_pkg::OP_VSETUP :
                   (op_r == ddpc_pkg::OP_VMAG) ? ddpc_pkg::OP_ALPHA :
                   (op_r == ddpc_pkg::OP_MODO) ? ddpc_pkg::OP_RSETUP :
                   ddpc_pkg::op_t'(op_r + 5'd1);
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      op_r <= ddpc_pkg::OP_NONE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
